// ===== hw/rtl/mcw_pkg.sv =====
package mcw_pkg;

   localparam int SLOTS      = 16;
   localparam int KEY_BITS   = 16;
   localparam int COUNT_BITS = 16;

   // payload fields are 16 bits wide; stored keys and counts keep only what fits both
   localparam int FIELD_W = 16;
   localparam int KEY_W   = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
   localparam int CNT_W   = (COUNT_BITS < FIELD_W) ? COUNT_BITS : FIELD_W;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_CREATE = 3'd1,
      OP_DELETE = 3'd2,
      OP_FEED   = 3'd3,
      OP_QUERY  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_PRESENT   = 3'd2,
      ST_FULL      = 3'd3,
      ST_HALTED    = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [FIELD_W-1:0] client_key;
      logic [FIELD_W-1:0] reload_ticks;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               expired;
      logic [FIELD_W-1:0] expired_key;
      logic [FIELD_W-1:0] remaining;
      logic [FIELD_W-1:0] reload_value;
   } rsp_type;

   // request broadcast to every cell
   typedef struct packed {
      logic             tick;
      logic             create;
      logic             delete_en;
      logic             feed;
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] reload;
   } cmd_type;

   // summary from the end of the row, fed back to all cells
   typedef struct packed {
      logic any_match;
      logic any_zero;
   } glob_type;

   // passed from cell to cell along the row
   typedef struct packed {
      logic             match_seen;
      logic             free_seen;
      logic             zero_seen;
      logic [KEY_W-1:0] exp_key;
      logic [CNT_W-1:0] rem;
      logic [CNT_W-1:0] rel;
   } link_type;

endpackage

// ===== hw/rtl/mcw_cell.sv =====
module mcw_cell
   import mcw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  glob_type glob,
   input  link_type link_i,
   output link_type link_o
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] rel_ff, rel_in;
   logic [CNT_W-1:0] rem_ff, rem_in;

   logic match, zero, free_slot;
   logic sel_match, sel_free, sel_zero;

   always_comb begin
      match     = valid_ff && (key_ff == cmd.key);
      zero      = valid_ff && (rem_ff == '0);
      free_slot = !valid_ff;
      sel_match = match && !link_i.match_seen;
      sel_free  = free_slot && !link_i.free_seen;
      sel_zero  = zero && !link_i.zero_seen;

      link_o.match_seen = link_i.match_seen | match;
      link_o.free_seen  = link_i.free_seen | free_slot;
      link_o.zero_seen  = link_i.zero_seen | zero;
      link_o.exp_key    = link_i.exp_key | (sel_zero ? key_ff : '0);
      link_o.rem        = link_i.rem | (sel_match ? rem_ff : '0);
      link_o.rel        = link_i.rel | (sel_match ? rel_ff : '0);

      valid_in = valid_ff;
      key_in   = key_ff;
      rel_in   = rel_ff;
      rem_in   = rem_ff;
      if (cmd.create && !glob.any_match && sel_free) begin
         valid_in = 1'b1;
         key_in   = cmd.key;
         rel_in   = cmd.reload;
         rem_in   = cmd.reload;
      end
      if (cmd.delete_en && match) begin
         valid_in = 1'b0;
      end
      if (cmd.feed && match) begin
         rem_in = rel_ff;
      end
      if (cmd.tick && !glob.any_zero && valid_ff) begin
         rem_in = rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      rel_ff <= rel_in;
      rem_ff <= rem_in;
   end

endmodule

// ===== hw/rtl/mcw_row.sv =====
module mcw_row
   import mcw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  glob_type glob,
   output link_type link_end
);

   link_type link [SLOTS+1];

   assign link[0] = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      mcw_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cmd),
         .glob   (glob),
         .link_i (link[i]),
         .link_o (link[i+1])
      );
   end

   assign link_end = link[SLOTS];

endmodule

// ===== hw/rtl/multi_channel_watchdog_core.sv =====
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | req_data (req_type)
// rsp     | out       | rsp_valid/rsp_stall | rsp_data (rsp_type)
//
// One request is taken per cycle while req_stall is low; its response is registered and shows in the next cycle.
// Each cell compares and counts on its own; lowest-slot choices ripple along the cell row.
// req_stall is high while a response is held by rsp_stall.
// Synchronous reset clears all slot valid bits and the tripped flag; no clearing pass.
module multi_channel_watchdog_core
   import mcw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;
   logic     tripped_ff, tripped_in;
   logic     accept, live;
   cmd_type  cmd;
   glob_type glob;
   link_type link_end;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign live      = accept && !tripped_ff;

   always_comb begin
      cmd.tick      = live && (req_data.op == OP_TICK);
      cmd.create    = live && (req_data.op == OP_CREATE);
      cmd.delete_en = live && (req_data.op == OP_DELETE);
      cmd.feed      = live && (req_data.op == OP_FEED);
      cmd.key       = req_data.client_key[KEY_W-1:0];
      cmd.reload    = req_data.reload_ticks[CNT_W-1:0];
      glob.any_match = link_end.match_seen;
      glob.any_zero  = link_end.zero_seen;
   end

   mcw_row u_row (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .glob     (glob),
      .link_end (link_end)
   );

   always_comb begin
      rsp_data_in = '0;
      tripped_in  = tripped_ff;
      if (tripped_ff) begin
         rsp_data_in.status = ST_HALTED;
      end else begin
         case (req_data.op)
            OP_TICK: begin
               if (link_end.zero_seen) begin
                  tripped_in              = accept;
                  rsp_data_in.status      = ST_HALTED;
                  rsp_data_in.expired     = 1'b1;
                  rsp_data_in.expired_key = FIELD_W'(link_end.exp_key);
               end
            end
            OP_CREATE: begin
               if (link_end.match_seen) begin
                  rsp_data_in.status = ST_PRESENT;
               end else if (!link_end.free_seen) begin
                  rsp_data_in.status = ST_FULL;
               end
            end
            OP_DELETE: begin
               if (!link_end.match_seen) begin
                  rsp_data_in.status = ST_NOT_FOUND;
               end
            end
            OP_FEED: begin
               if (!link_end.match_seen) begin
                  rsp_data_in.status = ST_NOT_FOUND;
               end else begin
                  rsp_data_in.remaining = FIELD_W'(link_end.rel);
               end
            end
            OP_QUERY: begin
               if (!link_end.match_seen) begin
                  rsp_data_in.status = ST_NOT_FOUND;
               end else begin
                  rsp_data_in.remaining    = FIELD_W'(link_end.rem);
                  rsp_data_in.reload_value = FIELD_W'(link_end.rel);
               end
            end
            default: begin
               rsp_data_in.status = ST_OK;
            end
         endcase
      end
      tripped_in   = tripped_in | tripped_ff;
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tripped_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         tripped_ff   <= tripped_in;
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/mcw_checker.sv =====
module mcw_checker
   import mcw_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request gave no response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while response held");

   a_expired_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.expired) |->
         (rsp_data.status == ST_HALTED && rsp_data.remaining == '0))
      else $error("expiry without halt");

endmodule

bind multi_channel_watchdog_core mcw_checker u_mcw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import mcw_pkg::*;

   localparam int OP_CODE_MAX   = 7;
   localparam int RANDOM_ITEMS  = 910;
   localparam int QUIET_FROM    = 300;
   localparam int QUIET_TO      = 420;
   localparam int PAUSE_AT      = 500;
   localparam int HOLD_AT       = 150;
   localparam int HOLD_CYCLES   = 60;
   localparam int FREE_RUN_FROM = 600;
   localparam int FREE_RUN_TO   = 720;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 200000;

   class watchdog_scoreboard;
      bit             live [SLOTS];
      bit [KEY_W-1:0] key_of [SLOTS];
      bit [CNT_W-1:0] reload_of [SLOTS];
      bit [CNT_W-1:0] left_of [SLOTS];
      bit             halted;
      rsp_type        awaited_responses [$];
      int             failures;

      function int find_key(bit [KEY_W-1:0] k);
         for (int i = 0; i < SLOTS; i++)
            if (live[i] && key_of[i] == k) return i;
         return -1;
      endfunction

      function int first_zero();
         for (int i = 0; i < SLOTS; i++)
            if (live[i] && left_of[i] == 0) return i;
         return -1;
      endfunction

      function void note_request(req_type r);
         rsp_type        want;
         int             s;
         bit [KEY_W-1:0] k;
         bit [CNT_W-1:0] n;
         want = '0;
         k = r.client_key[KEY_W-1:0];
         n = r.reload_ticks[CNT_W-1:0];
         if (halted) begin
            want.status = ST_HALTED;
         end else begin
            case (r.op)
               OP_TICK: begin
                  s = first_zero();
                  if (s >= 0) begin
                     halted = 1'b1;
                     want.status = ST_HALTED;
                     want.expired = 1'b1;
                     want.expired_key = key_of[s];
                  end else begin
                     foreach (live[i])
                        if (live[i]) left_of[i]--;
                  end
               end
               OP_CREATE: begin
                  if (find_key(k) >= 0) begin
                     want.status = ST_PRESENT;
                  end else begin
                     s = -1;
                     for (int i = SLOTS - 1; i >= 0; i--)
                        if (!live[i]) s = i;
                     if (s < 0) begin
                        want.status = ST_FULL;
                     end else begin
                        live[s] = 1'b1;
                        key_of[s] = k;
                        reload_of[s] = n;
                        left_of[s] = n;
                     end
                  end
               end
               OP_DELETE, OP_FEED, OP_QUERY: begin
                  s = find_key(k);
                  if (s < 0) begin
                     want.status = ST_NOT_FOUND;
                  end else if (r.op == OP_DELETE) begin
                     live[s] = 1'b0;
                  end else begin
                     if (r.op == OP_FEED) left_of[s] = reload_of[s];
                     want.remaining = left_of[s];
                     if (r.op == OP_QUERY) want.reload_value = reload_of[s];
                  end
               end
               default: ;
            endcase
         end
         awaited_responses.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_responses.size() == 0) begin
            $error("response %h arrived with no request outstanding", got);
            failures++;
            return;
         end
         want = awaited_responses.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.expired !== want.expired) begin
            $error("expired: expected %0d, got %0d", want.expired, got.expired);
            failures++;
         end
         if (got.expired_key !== want.expired_key) begin
            $error("expired_key: expected %h, got %h", want.expired_key, got.expired_key);
            failures++;
         end
         if (got.remaining !== want.remaining) begin
            $error("remaining: expected %h, got %h", want.remaining, got.remaining);
            failures++;
         end
         if (got.reload_value !== want.reload_value) begin
            $error("reload_value: expected %h, got %h", want.reload_value, got.reload_value);
            failures++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   watchdog_scoreboard board = new;
   bit steady;
   int responses_seen;
   int hold_left;
   bit hold_done;
   int cycle_count;

   multi_channel_watchdog_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off, one stretch with no stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_response(rsp_data);
         responses_seen++;
      end
      if (responses_seen == HOLD_AT && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (reset || (responses_seen >= FREE_RUN_FROM && responses_seen < FREE_RUN_TO)) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 32);
      end
   end

   function automatic req_type make_req(input logic [2:0] op, input logic [15:0] client_key,
                                        input logic [15:0] reload_ticks);
      req_type r;
      r.op = op;
      r.client_key = client_key;
      r.reload_ticks = reload_ticks;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      roll;
      int      s;
      int      hit;
      r.client_key = ($urandom_range(99) < 70) ? 16'($urandom_range(23)) : 16'($urandom);
      r.reload_ticks = ($urandom_range(99) < 85) ? 16'($urandom_range(12)) : 16'($urandom);
      roll = $urandom_range(99);
      if (roll < 30)      r.op = OP_TICK;
      else if (roll < 50) r.op = OP_CREATE;
      else if (roll < 62) r.op = OP_DELETE;
      else if (roll < 78) r.op = OP_FEED;
      else if (roll < 96) r.op = OP_QUERY;
      else                r.op = 3'($urandom_range(OP_CODE_MAX, OP_QUERY + 1));
      // most lookups should hit a live channel
      if (r.op inside {OP_DELETE, OP_FEED, OP_QUERY} && $urandom_range(3) != 0) begin
         hit = -1;
         repeat (4) begin
            s = $urandom_range(SLOTS - 1);
            if (board.live[s]) hit = s;
         end
         if (hit >= 0) r.client_key = board.key_of[hit];
      end
      // a tick now would trip for good; retire or refeed the dry channel instead
      if (r.op == OP_TICK) begin
         s = board.first_zero();
         if (s >= 0) begin
            r.client_key = board.key_of[s];
            r.op = (board.reload_of[s] != 0 && $urandom_range(1)) ? OP_FEED : OP_DELETE;
         end
      end
      return r;
   endfunction

   task automatic issue(input req_type r);
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(r);
      if (!steady && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   initial begin
      int k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      issue(make_req(OP_TICK, 16'h0000, 16'h0000));      // empty table
      issue(make_req(OP_CREATE, 16'h0000, 16'h0000));    // zero reload
      issue(make_req(OP_CREATE, 16'hFFFF, 16'hFFFF));
      issue(make_req(OP_CREATE, 16'h0000, 16'h0005));    // duplicate key
      issue(make_req(OP_QUERY, 16'h0000, 16'h0000));
      issue(make_req(OP_FEED, 16'h0000, 16'h0000));
      issue(make_req(OP_DELETE, 16'h0000, 16'h0000));
      issue(make_req(OP_DELETE, 16'h0000, 16'h0000));    // gone now
      issue(make_req(OP_FEED, 16'h1234, 16'h0000));
      issue(make_req(OP_TICK, 16'h0000, 16'h0000));
      issue(make_req(OP_QUERY, 16'hFFFF, 16'h0000));
      issue(make_req(OP_FEED, 16'hFFFF, 16'h0000));
      issue(make_req(3'(OP_CODE_MAX), 16'hFFFF, 16'hFFFF));
      for (int i = 1; i < SLOTS; i++)
         issue(make_req(OP_CREATE, 16'(i), 16'($urandom_range(40, 1))));
      issue(make_req(OP_CREATE, 16'hAAAA, 16'h0001));    // table full
      issue(make_req(OP_CREATE, 16'hFFFF, 16'h0001));    // duplicate checked before full

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= QUIET_FROM && n < QUIET_TO);
         if (n == PAUSE_AT) begin
            req_valid <= 1'b0;
            while (board.awaited_responses.size() != 0) @(posedge clock);
         end
         issue(random_request());
      end
      steady = 1'b0;

      // dry out two low channels so the trip reports the lowest one
      if (board.live[2]) issue(make_req(OP_DELETE, board.key_of[2], 16'h0000));
      if (board.live[5]) issue(make_req(OP_DELETE, board.key_of[5], 16'h0000));
      repeat (2) begin
         do k = $urandom_range(16'hFFFF); while (board.find_key(16'(k)) >= 0);
         issue(make_req(OP_CREATE, 16'(k), 16'h0000));
      end
      issue(make_req(OP_TICK, 16'h0000, 16'h0000));
      // everything after the trip is halted
      issue(make_req(OP_QUERY, 16'(k), 16'h0000));
      issue(make_req(OP_CREATE, 16'h7777, 16'h0003));
      issue(make_req(OP_TICK, 16'h0000, 16'h0000));

      req_valid <= 1'b0;
      while (board.awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/mcw_pkg.sv
hw/rtl/mcw_cell.sv
hw/rtl/mcw_row.sv
hw/rtl/multi_channel_watchdog_core.sv
hw/rtl/mcw_checker.sv
tb/testbench.sv
